@@ hdl/bgdr_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgdr_pkg
// shared types, register codes and master palette for the background renderer
// ---------------------------------------------------------------------------
package bgdr_pkg;

	typedef struct packed {
		logic       action;
		logic [2:0] reg_index;
		logic [7:0] reg_data;
	} item_t;

	typedef struct packed {
		logic       pixel_valid;
		logic [7:0] pixel_x;
		logic [7:0] pixel_y;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       nmi_pulse;
		logic       frame_done;
		logic       vblank;
	} result_t;

	localparam logic       ACT_TICK    = 1'b0;
	localparam logic [2:0] REG_CONTROL = 3'd0;
	localparam logic [2:0] REG_ADDRESS = 3'd6;
	localparam logic [2:0] REG_DATA    = 3'd7;

	localparam logic [15:0] ADDR_NAMETABLE = 16'h2000;
	localparam logic [15:0] ADDR_VRAM_END  = 16'h3000;
	localparam logic [15:0] ADDR_PALETTE   = 16'h3F00;
	localparam logic [15:0] ADDR_PAL_END   = 16'h3F20;
	localparam logic [10:0] ATTR_OFFSET    = 11'h3C0;

	// 64-entry master palette, rgb packed as {r, g, b}
	function automatic logic [23:0] master_rgb(input logic [5:0] k);
		logic [23:0] c;
		case (k)
			6'd0:  c = {8'd84, 8'd84, 8'd84};
			6'd1:  c = {8'd0, 8'd30, 8'd116};
			6'd2:  c = {8'd8, 8'd16, 8'd144};
			6'd3:  c = {8'd48, 8'd0, 8'd136};
			6'd4:  c = {8'd68, 8'd0, 8'd100};
			6'd5:  c = {8'd92, 8'd0, 8'd48};
			6'd6:  c = {8'd84, 8'd4, 8'd0};
			6'd7:  c = {8'd60, 8'd24, 8'd0};
			6'd8:  c = {8'd32, 8'd42, 8'd0};
			6'd9:  c = {8'd8, 8'd58, 8'd0};
			6'd10: c = {8'd0, 8'd64, 8'd0};
			6'd11: c = {8'd0, 8'd60, 8'd0};
			6'd12: c = {8'd0, 8'd50, 8'd60};
			6'd16: c = {8'd152, 8'd150, 8'd152};
			6'd17: c = {8'd8, 8'd76, 8'd196};
			6'd18: c = {8'd48, 8'd50, 8'd236};
			6'd19: c = {8'd92, 8'd30, 8'd228};
			6'd20: c = {8'd136, 8'd20, 8'd176};
			6'd21: c = {8'd160, 8'd20, 8'd100};
			6'd22: c = {8'd152, 8'd34, 8'd32};
			6'd23: c = {8'd120, 8'd60, 8'd0};
			6'd24: c = {8'd84, 8'd90, 8'd0};
			6'd25: c = {8'd40, 8'd114, 8'd0};
			6'd26: c = {8'd8, 8'd124, 8'd0};
			6'd27: c = {8'd0, 8'd118, 8'd40};
			6'd28: c = {8'd0, 8'd102, 8'd120};
			6'd32: c = {8'd236, 8'd238, 8'd236};
			6'd33: c = {8'd76, 8'd154, 8'd236};
			6'd34: c = {8'd120, 8'd124, 8'd236};
			6'd35: c = {8'd176, 8'd98, 8'd236};
			6'd36: c = {8'd228, 8'd84, 8'd236};
			6'd37: c = {8'd236, 8'd88, 8'd180};
			6'd38: c = {8'd236, 8'd106, 8'd100};
			6'd39: c = {8'd212, 8'd136, 8'd32};
			6'd40: c = {8'd160, 8'd170, 8'd0};
			6'd41: c = {8'd116, 8'd196, 8'd0};
			6'd42: c = {8'd76, 8'd208, 8'd32};
			6'd43: c = {8'd56, 8'd204, 8'd108};
			6'd44: c = {8'd56, 8'd180, 8'd204};
			6'd45: c = {8'd60, 8'd60, 8'd60};
			6'd48: c = {8'd236, 8'd238, 8'd236};
			6'd49: c = {8'd168, 8'd204, 8'd236};
			6'd50: c = {8'd188, 8'd188, 8'd236};
			6'd51: c = {8'd212, 8'd178, 8'd236};
			6'd52: c = {8'd236, 8'd174, 8'd236};
			6'd53: c = {8'd236, 8'd174, 8'd212};
			6'd54: c = {8'd236, 8'd180, 8'd176};
			6'd55: c = {8'd228, 8'd196, 8'd144};
			6'd56: c = {8'd204, 8'd210, 8'd120};
			6'd57: c = {8'd180, 8'd222, 8'd120};
			6'd58: c = {8'd168, 8'd226, 8'd144};
			6'd59: c = {8'd152, 8'd226, 8'd180};
			6'd60: c = {8'd160, 8'd214, 8'd228};
			6'd61: c = {8'd160, 8'd162, 8'd160};
			default: c = 24'd0;
		endcase
		return c;
	endfunction

endpackage

@@ hdl/bgdr_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// bgdr_ram
// generic one-write one-read ram with registered read data
// ---------------------------------------------------------------------------
module bgdr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/ppu_background_dot_renderer_unit.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ppu_background_dot_renderer_unit
// background renderer of a 2c02-style picture unit, one dot per tick item
// ---------------------------------------------------------------------------
// One item is taken per clock while the result side does not stall. It
// lands in the input register, passes one level of logic and its result
// item is registered in the result register, which raises result_valid.
// The nametable, attribute and pattern reads are issued by the item that
// fetches and land in their latches on the following cycle; the next item
// sees them through a forwarding mux, so ticks stream at one per clock
// while the result side does not stall. A stalled result holds the item in
// the input register, and item_stall stays high until the result side
// moves. After reset the video ram is cleared one byte per cycle, during
// which item_stall is held high. Pattern ram is not cleared.
module ppu_background_dot_renderer_unit
	import bgdr_pkg::*;
#(
	parameter int VIDEO_RAM_BYTES = 2048,
	parameter int PATTERN_BYTES   = 8192
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	localparam int VAW = $clog2(VIDEO_RAM_BYTES);
	localparam int PAW = $clog2(PATTERN_BYTES);

	// input stage
	logic  v_s1;
	item_t it_s1;
	logic  go;

	// frame state
	logic [8:0]  ln_q, n_ln;
	logic [9:0]  dot_q, n_dot;
	logic [2:0]  ph_q, n_ph;
	logic [8:0]  dcol_q, n_dcol;
	logic [8:0]  drow_q, n_drow;
	logic [5:0]  tc_q, n_tc;
	logic [5:0]  tr_q, n_tr;
	logic [7:0]  tile_q, n_tile;
	logic [7:0]  attr_q, n_attr;
	logic [7:0]  plo_q, n_plo;
	logic [15:0] shh_q, n_shh;
	logic [15:0] shl_q, n_shl;
	logic [7:0]  ctrl_q, n_ctrl;
	logic [15:0] addr_q, n_addr;
	logic        vbl_q, n_vbl;
	logic        ie_q, n_ie;
	logic [23:0] pal_q [16];

	// reads in flight, each lands the cycle after issue
	logic pend_tile_q, pend_attr_q, pend_plo_q, pend_phi_q, pend_up_q;
	logic n_pend_tile, n_pend_attr, n_pend_plo, n_pend_phi, n_pend_up;

	// memory ports
	logic [7:0]     vram_rd, pat_rd;
	logic [10:0]    vram_ra11;
	logic [12:0]    pat_ra13;
	logic           vram_we, pat_we;
	logic [10:0]    vram_wa11;
	logic [12:0]    pat_wa13;
	logic [VAW-1:0] vram_waddr;
	logic [7:0]     mem_wdata;
	logic           pal_we;
	logic [3:0]     pal_idx;

	// clearing pass
	logic           clr_busy_q;
	logic [VAW-1:0] clr_addr_q;

	// per-item scratch
	logic        do_fetch, prefetch;
	logic [2:0]  frow;
	logic [9:0]  d;
	logic [12:0] pa;
	logic [10:0] nt_low;
	logic [1:0]  pv, pal_sel;
	logic [2:0]  ash;
	logic [23:0] colour;
	result_t     res;

	assign go         = v_s1 && (!result_valid || !result_stall);
	assign item_stall = clr_busy_q || (v_s1 && !go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!item_stall) begin
			v_s1 <= item_valid;
		end else if (go) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!item_stall && item_valid) begin
			it_s1 <= item;
		end
	end

	// pattern index reduced modulo PATTERN_BYTES (value always below twice it)
	function automatic logic [PAW-1:0] pat_index(input logic [12:0] a);
		logic [13:0] w;
		w = {1'b0, a};
		if (w >= 14'(PATTERN_BYTES)) begin
			w = w - 14'(PATTERN_BYTES);
		end
		return PAW'(w);
	endfunction

	always_comb begin
		// landed reads are committed whether or not an item is here
		n_tile = pend_tile_q ? vram_rd : tile_q;
		n_attr = pend_attr_q ? vram_rd : attr_q;
		n_plo  = pend_plo_q ? pat_rd : plo_q;
		n_shh  = shh_q;
		n_shl  = shl_q;
		if (pend_phi_q) begin
			n_shh = shh_q | (pend_up_q ? {pat_rd, 8'h00} : {8'h00, pat_rd});
			n_shl = shl_q | (pend_up_q ? {plo_q, 8'h00} : {8'h00, plo_q});
		end
		n_ln   = ln_q;
		n_dot  = dot_q;
		n_ph   = ph_q;
		n_dcol = dcol_q;
		n_drow = drow_q;
		n_tc   = tc_q;
		n_tr   = tr_q;
		n_ctrl = ctrl_q;
		n_addr = addr_q;
		n_vbl  = vbl_q;
		n_ie   = ie_q;
		n_pend_tile = 1'b0;
		n_pend_attr = 1'b0;
		n_pend_plo  = 1'b0;
		n_pend_phi  = 1'b0;
		n_pend_up   = 1'b0;
		res       = '0;
		vram_ra11 = '0;
		pat_ra13  = '0;
		vram_we   = 1'b0;
		vram_wa11 = addr_q[10:0];
		pat_we    = 1'b0;
		pat_wa13  = addr_q[12:0];
		mem_wdata = it_s1.reg_data;
		pal_we    = 1'b0;
		pal_idx   = addr_q[3:0];
		do_fetch  = 1'b0;
		prefetch  = 1'b0;
		frow      = ln_q[2:0];
		d         = dot_q;
		pa        = '0;
		nt_low    = '0;
		pv        = '0;
		pal_sel   = '0;
		ash       = '0;
		colour    = '0;

		if (go) begin
			if (it_s1.action != ACT_TICK) begin
				unique case (it_s1.reg_index)
					REG_CONTROL: begin
						n_ctrl = it_s1.reg_data;
						n_ie   = it_s1.reg_data[7];
					end
					REG_ADDRESS: begin
						n_addr = {addr_q[7:0], it_s1.reg_data};
					end
					REG_DATA: begin
						if (addr_q < ADDR_NAMETABLE) begin
							pat_we = 1'b1;
						end else if (addr_q < ADDR_VRAM_END) begin
							vram_we = 1'b1;
						end else if (addr_q > ADDR_PALETTE && addr_q < ADDR_PAL_END) begin
							pal_we = !addr_q[4] && (addr_q[1:0] != 2'd0);
						end
						n_addr = addr_q + (ctrl_q[2] ? 16'd32 : 16'd1);
					end
					default: begin
					end
				endcase
			end else if (ln_q <= 9'd239) begin
				if (d == 10'd0) begin
					n_dcol = '0;
				end else if (d <= 10'd256) begin
					n_tc = 6'd2 + 6'((d - 10'd1) >> 3);
					n_tr = drow_q[8:3];
					// draw from the top bits of the shifters
					pv      = {n_shh[15], n_shl[15]};
					ash     = {n_tr[1], n_tc[1], 1'b0};
					pal_sel = 2'((n_attr >> ash) & 8'd3);
					colour  = pal_q[{pal_sel, pv}];
					res.pixel_valid = 1'b1;
					res.pixel_x     = dcol_q[7:0];
					res.pixel_y     = drow_q[7:0];
					res.red         = colour[23:16];
					res.green       = colour[15:8];
					res.blue        = colour[7:0];
					n_dcol = dcol_q + 9'd1;
					n_shh  = {n_shh[14:0], 1'b0};
					n_shl  = {n_shl[14:0], 1'b0};
					do_fetch = 1'b1;
				end else if (d <= 10'd320) begin
					if (d == 10'd257) begin
						n_shh  = '0;
						n_shl  = '0;
						n_tc   = '0;
						n_ln   = ln_q + 9'd1;
						n_drow = drow_q + 9'd1;
					end
				end else if (d <= 10'd336) begin
					n_tr     = drow_q[8:3];
					do_fetch = 1'b1;
					prefetch = 1'b1;
				end
				n_dot = (d > 10'd340) ? 10'd0 : d + 10'd1;
			end else if (ln_q <= 9'd260) begin
				if (ln_q == 9'd241 && d == 10'd1) begin
					n_vbl = 1'b1;
					res.frame_done = 1'b1;
				end
				if (ln_q != 9'd240 && ie_q) begin
					n_ie = 1'b0;
					res.nmi_pulse = 1'b1;
				end
				if (d == 10'd340) begin
					n_ln   = ln_q + 9'd1;
					n_drow = drow_q + 9'd1;
					n_dot  = 10'd1;
				end else begin
					n_dot = d + 10'd1;
				end
			end else if (ln_q == 9'd261) begin
				if (d == 10'd1) begin
					n_tc  = '0;
					n_vbl = 1'b0;
				end
				if (d >= 10'd321 && d <= 10'd336) begin
					n_tr     = '0;
					frow     = '0;
					do_fetch = 1'b1;
					prefetch = 1'b1;
					n_dot    = d + 10'd1;
				end else if (d == 10'd340) begin
					n_ln   = '0;
					n_drow = '0;
					n_dot  = '0;
				end else begin
					n_dot = d + 10'd1;
				end
			end

			if (do_fetch) begin
				nt_low = {ctrl_q[0], 10'd0};
				pa = (ctrl_q[4] ? 13'h1000 : 13'h0000) + {1'b0, n_tile, 4'd0}
					+ {10'd0, frow};
				case (ph_q)
					3'd1: begin
						vram_ra11   = nt_low + {5'd0, n_tc} + {n_tr, 5'd0};
						n_pend_tile = 1'b1;
					end
					3'd3: begin
						vram_ra11 = nt_low + {7'd0, n_tc[5:2]} + {4'd0, n_tr[5:2], 3'd0}
							+ ATTR_OFFSET;
						n_pend_attr = 1'b1;
					end
					3'd5: begin
						pat_ra13   = pa;
						n_pend_plo = 1'b1;
					end
					3'd7: begin
						pat_ra13   = pa + 13'd8;
						n_pend_phi = 1'b1;
						n_pend_up  = prefetch && d == 10'd328;
					end
					default: begin
					end
				endcase
				n_ph = ph_q + 3'd1;
				if (n_ph == 3'd0 && prefetch && d == 10'd328) begin
					n_tc  = n_tc + 6'd1;
					n_shh = {n_shh[7:0], 8'h00};
					n_shl = {n_shl[7:0], 8'h00};
				end
			end
			res.vblank = n_vbl;
		end
	end

	assign vram_waddr = clr_busy_q ? clr_addr_q : VAW'(vram_wa11);

	bgdr_ram #(
		.WIDTH(8),
		.DEPTH(VIDEO_RAM_BYTES)
	) u_vram (
		.clk   (clk),
		.we    (clr_busy_q || vram_we),
		.waddr (vram_waddr),
		.wdata (clr_busy_q ? 8'h00 : mem_wdata),
		.raddr (VAW'(vram_ra11)),
		.rdata (vram_rd)
	);

	bgdr_ram #(
		.WIDTH(8),
		.DEPTH(PATTERN_BYTES)
	) u_pattern (
		.clk   (clk),
		.we    (pat_we),
		.waddr (pat_index(pat_wa13)),
		.wdata (mem_wdata),
		.raddr (pat_index(pat_ra13)),
		.rdata (pat_rd)
	);

	// clearing pass over video ram after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + VAW'(1);
			if (clr_addr_q == VAW'(VIDEO_RAM_BYTES - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// background palette entries, stored as rgb
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) begin
				pal_q[i] <= '0;
			end
		end else if (pal_we) begin
			pal_q[pal_idx] <= master_rgb(it_s1.reg_data[5:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ln_q   <= '0;
			dot_q  <= '0;
			ph_q   <= '0;
			dcol_q <= '0;
			drow_q <= '0;
			tc_q   <= '0;
			tr_q   <= '0;
			tile_q <= '0;
			attr_q <= '0;
			plo_q  <= '0;
			shh_q  <= '0;
			shl_q  <= '0;
			ctrl_q <= '0;
			addr_q <= '0;
			vbl_q  <= 1'b0;
			ie_q   <= 1'b0;
			pend_tile_q <= 1'b0;
			pend_attr_q <= 1'b0;
			pend_plo_q  <= 1'b0;
			pend_phi_q  <= 1'b0;
			pend_up_q   <= 1'b0;
		end else begin
			ln_q   <= n_ln;
			dot_q  <= n_dot;
			ph_q   <= n_ph;
			dcol_q <= n_dcol;
			drow_q <= n_drow;
			tc_q   <= n_tc;
			tr_q   <= n_tr;
			tile_q <= n_tile;
			attr_q <= n_attr;
			plo_q  <= n_plo;
			shh_q  <= n_shh;
			shl_q  <= n_shl;
			ctrl_q <= n_ctrl;
			addr_q <= n_addr;
			vbl_q  <= n_vbl;
			ie_q   <= n_ie;
			pend_tile_q <= n_pend_tile;
			pend_attr_q <= n_pend_attr;
			pend_plo_q  <= n_pend_plo;
			pend_phi_q  <= n_pend_phi;
			pend_up_q   <= n_pend_up;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (go) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			result <= res;
		end
	end

	// at most one memory read lands per cycle
	a_one_pending: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({pend_tile_q, pend_attr_q, pend_plo_q, pend_phi_q}))
		else $error("more than one fetch in flight");

	// no item enters while video ram is being cleared
	a_clear_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> item_stall)
		else $error("item accepted during clearing pass");

	// a drawn pixel never carries the vblank flag
	a_pixel_not_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.pixel_valid) |-> !result.vblank)
		else $error("pixel drawn during vblank");

	// frame end always reports vblank set
	a_frame_vblank: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.frame_done) |-> result.vblank)
		else $error("frame done without vblank");

endmodule
